FILE: src/ptwa_pkg.sv
// ----------------------------------------------------------------------------
// ptwa_pkg
// Types and constants shared by the presence table with aging.
// ----------------------------------------------------------------------------
package ptwa_pkg;

   localparam int ROM_W   = 64;
   localparam int CNT_W   = 8;
   localparam int TOT_W   = 6;
   localparam int CSR_A_W = 8;
   localparam int CSR_D_W = 8;

   // operation codes
   localparam logic [1:0] OP_FOUND     = 2'd0;
   localparam logic [1:0] OP_SCAN_END  = 2'd1;
   localparam logic [1:0] OP_EMPTY_BUS = 2'd2;
   localparam logic [1:0] OP_READ_DONE = 2'd3;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_FAMILY_CODE      = 8'd0;
   localparam logic [CSR_A_W-1:0] CSR_ABSENT_THRESHOLD = 8'd1;
   localparam logic [CSR_A_W-1:0] CSR_EVICT_THRESHOLD  = 8'd2;
   localparam logic [CSR_A_W-1:0] CSR_ABSENCE_CEILING  = 8'd3;

   // register reset values
   localparam logic [CSR_D_W-1:0] RST_FAMILY_CODE      = 8'h2D;
   localparam logic [CSR_D_W-1:0] RST_ABSENT_THRESHOLD = 8'd3;
   localparam logic [CSR_D_W-1:0] RST_EVICT_THRESHOLD  = 8'd5;
   localparam logic [CSR_D_W-1:0] RST_ABSENCE_CEILING  = 8'd250;

   // result kinds
   localparam logic KIND_READ_REQ = 1'b0;
   localparam logic KIND_SUMMARY  = 1'b1;

   typedef struct packed {
      logic [1:0]       op;
      logic [ROM_W-1:0] rom_id;
      logic             full_read;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [ROM_W-1:0] req_rom;
      logic [TOT_W-1:0] entry_total;
      logic [TOT_W-1:0] present_total;
      logic             changed;
      logic             dropped;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [ROM_W-1:0] rom;
      logic [CNT_W-1:0] count;
      logic             present;
      logic             assigned;
      logic             seen;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WALK,
      ST_EMIT,
      ST_SUMMARY
   } state_type;

endpackage

FILE: src/ptwa_ram.sv
// ----------------------------------------------------------------------------
// ptwa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/presence_table_with_aging.sv
// ----------------------------------------------------------------------------
// presence_table_with_aging
// Ordered table of device IDs with absence aging, read requests and
// order-preserving eviction. Entries live in one RAM, pending read
// requests of a scan in a second RAM.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  input   | start, busy, req_item          | start & !busy
//  result  | rsp_valid, rsp_item            | strobe, one cycle, no stall
//  config  | csr_valid, csr_ready, csr_*    | csr_valid & csr_ready
//
//  Found ID / read done: a table search, one entry read per cycle.
//  End of scan: a walk that ages and compacts the table, then the
//  read requests are emitted from the request RAM, then one summary.
//  Empty bus: a walk that ages without eviction, plus the summary.
//  Results leave in the cycle after they are formed. Reset is
//  synchronous; no clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module presence_table_with_aging #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ptwa_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output ptwa_pkg::rsp_type                 rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptwa_pkg::CSR_A_W-1:0]      csr_index,
   input  logic [ptwa_pkg::CSR_D_W-1:0]      csr_wdata
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = $bits(ptwa_pkg::entry_type);

   ptwa_pkg::state_type state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic [ptwa_pkg::ROM_W-1:0] rom_ff, rom_in;
   logic                       full_ff, full_in;
   logic [CW-1:0]              rd_idx_ff, rd_idx_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [CW-1:0]              ret_idx_ff, ret_idx_in;
   logic [CW-1:0]              nreq_ff, nreq_in;
   logic [CW-1:0]              pres_ff, pres_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       changed_ff, changed_in;
   logic                       dropped_ff, dropped_in;
   logic [ptwa_pkg::CSR_D_W-1:0] family_ff, absthr_ff, evthr_ff, ceil_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   ptwa_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       ent_we;
   logic [AW-1:0]              ent_waddr, ent_raddr;
   ptwa_pkg::entry_type        ent_wdata, ent_rdata;
   logic [EW-1:0]              ent_rdata_raw;
   logic                       req_we;
   logic [AW-1:0]              req_waddr, req_raddr;
   logic [ptwa_pkg::ROM_W-1:0] req_wdata, req_rdata;

   ptwa_pkg::entry_type        upd;
   logic                       issue;

   // entry table
   ptwa_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata_raw)
   );
   assign ent_rdata = ptwa_pkg::entry_type'(ent_rdata_raw);

   // read requests of the current scan
   ptwa_ram #(.WIDTH(ptwa_pkg::ROM_W), .DEPTH(TABLE_ENTRIES)) u_req_ram (
      .clock (clock),
      .we    (req_we),
      .waddr (req_waddr),
      .wdata (req_wdata),
      .raddr (req_raddr),
      .rdata (req_rdata)
   );

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff <= ptwa_pkg::RST_FAMILY_CODE;
         absthr_ff <= ptwa_pkg::RST_ABSENT_THRESHOLD;
         evthr_ff  <= ptwa_pkg::RST_EVICT_THRESHOLD;
         ceil_ff   <= ptwa_pkg::RST_ABSENCE_CEILING;
      end else if (csr_valid) begin
         case (csr_index)
            ptwa_pkg::CSR_FAMILY_CODE:      family_ff <= csr_wdata;
            ptwa_pkg::CSR_ABSENT_THRESHOLD: absthr_ff <= csr_wdata;
            ptwa_pkg::CSR_EVICT_THRESHOLD:  evthr_ff  <= csr_wdata;
            ptwa_pkg::CSR_ABSENCE_CEILING:  ceil_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptwa_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         changed_ff   <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         changed_ff   <= changed_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      rom_ff     <= rom_in;
      full_ff    <= full_in;
      rd_idx_ff  <= rd_idx_in;
      ret_idx_ff <= ret_idx_in;
      nreq_ff    <= nreq_in;
      pres_ff    <= pres_in;
      rsp_ff     <= rsp_in;
   end

   // refresh or age the entry that returns from the RAM
   always_comb begin
      upd = ent_rdata;
      if (op_ff == ptwa_pkg::OP_SCAN_END && ent_rdata.seen) begin
         upd.present = 1'b1;
         upd.count   = '0;
      end else begin
         if (ent_rdata.count < ceil_ff) begin
            upd.count = ent_rdata.count + 8'd1;
         end
         if (upd.count >= absthr_ff) begin
            upd.present = 1'b0;
         end
      end
      upd.seen = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rom_in       = rom_ff;
      full_in      = full_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      ret_idx_in   = ret_idx_ff;
      nreq_in      = nreq_ff;
      pres_in      = pres_ff;
      count_in     = count_ff;
      changed_in   = changed_ff;
      dropped_in   = dropped_ff;
      ent_we       = 1'b0;
      ent_waddr    = ret_idx_ff[AW-1:0];
      ent_wdata    = ent_rdata;
      ent_raddr    = rd_idx_ff[AW-1:0];
      req_we       = 1'b0;
      req_waddr    = nreq_ff[AW-1:0];
      req_wdata    = ent_rdata.rom;
      req_raddr    = rd_idx_ff[AW-1:0];
      issue        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in.kind          = ptwa_pkg::KIND_READ_REQ;
      rsp_in.req_rom       = '0;
      rsp_in.entry_total   = ptwa_pkg::TOT_W'(count_ff);
      rsp_in.present_total = ptwa_pkg::TOT_W'(pres_ff);
      rsp_in.changed       = changed_ff;
      rsp_in.dropped       = dropped_ff;
      rsp_in.last          = 1'b0;

      case (state_ff)
         ptwa_pkg::ST_IDLE: begin
            if (start) begin
               op_in      = req_item.op;
               rom_in     = req_item.rom_id;
               full_in    = req_item.full_read;
               rd_idx_in  = '0;
               ret_idx_in = '0;
               nreq_in    = '0;
               pres_in    = '0;
               if (req_item.op == ptwa_pkg::OP_FOUND ||
                   req_item.op == ptwa_pkg::OP_READ_DONE) begin
                  state_in = ptwa_pkg::ST_SEARCH;
               end else begin
                  state_in = ptwa_pkg::ST_WALK;
               end
            end
         end

         ptwa_pkg::ST_SEARCH: begin
            // stream reads, compare as they return
            issue     = rd_idx_ff < count_ff;
            rd_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               ret_idx_in = ret_idx_ff + CW'(1);
               if (ent_rdata.rom == rom_ff) begin
                  ent_we = 1'b1;
                  if (op_ff == ptwa_pkg::OP_FOUND) begin
                     ent_wdata.seen = 1'b1;
                  end else begin
                     ent_wdata.assigned = 1'b1;
                     changed_in = 1'b1;
                  end
                  rd_vld_in = 1'b0;
                  state_in  = ptwa_pkg::ST_IDLE;
               end
            end else if (rd_idx_ff == count_ff) begin
               // no match: append a new ID of the family
               if (op_ff == ptwa_pkg::OP_FOUND && rom_ff[7:0] == family_ff) begin
                  if (count_ff < CW'(TABLE_ENTRIES)) begin
                     ent_we             = 1'b1;
                     ent_waddr          = count_ff[AW-1:0];
                     ent_wdata.rom      = rom_ff;
                     ent_wdata.count    = '0;
                     ent_wdata.present  = 1'b1;
                     ent_wdata.assigned = 1'b0;
                     ent_wdata.seen     = 1'b1;
                     count_in           = count_ff + CW'(1);
                     changed_in         = 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               state_in = ptwa_pkg::ST_IDLE;
            end
         end

         ptwa_pkg::ST_WALK: begin
            issue     = rd_idx_ff < count_ff;
            rd_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               ent_wdata = upd;
               if (op_ff == ptwa_pkg::OP_SCAN_END) begin
                  // queue a read request for a seen entry that is unassigned or on a full read
                  if (ent_rdata.seen && (full_ff || !ent_rdata.assigned)) begin
                     req_we  = 1'b1;
                     nreq_in = nreq_ff + CW'(1);
                  end
                  // drop evicted entries, compact the rest
                  if (upd.count >= evthr_ff) begin
                     changed_in = 1'b1;
                  end else begin
                     ent_we     = 1'b1;
                     ret_idx_in = ret_idx_ff + CW'(1);
                     if (upd.present) begin
                        pres_in = pres_ff + CW'(1);
                     end
                  end
               end else begin
                  ent_we     = 1'b1;
                  ret_idx_in = ret_idx_ff + CW'(1);
                  if (upd.present) begin
                     pres_in = pres_ff + CW'(1);
                  end
               end
            end else if (rd_idx_ff == count_ff) begin
               if (op_ff == ptwa_pkg::OP_SCAN_END) begin
                  count_in  = ret_idx_ff;
                  rd_idx_in = '0;
                  state_in  = ptwa_pkg::ST_EMIT;
               end else begin
                  state_in = ptwa_pkg::ST_SUMMARY;
               end
            end
         end

         ptwa_pkg::ST_EMIT: begin
            // drain queued read requests in table order
            issue     = rd_idx_ff < nreq_ff;
            rd_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = ptwa_pkg::KIND_READ_REQ;
               rsp_in.req_rom = req_rdata;
            end else if (rd_idx_ff == nreq_ff) begin
               state_in = ptwa_pkg::ST_SUMMARY;
            end
         end

         ptwa_pkg::ST_SUMMARY: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = ptwa_pkg::KIND_SUMMARY;
            rsp_in.last  = 1'b1;
            changed_in   = 1'b0;
            dropped_in   = 1'b0;
            state_in     = ptwa_pkg::ST_IDLE;
         end

         default: begin
            state_in = ptwa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ptwa_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count above table size");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> rsp_ff.kind == ptwa_pkg::KIND_SUMMARY)
      else $error("last result is not a summary");

   a_summary_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptwa_pkg::ST_SUMMARY |=> state_ff == ptwa_pkg::ST_IDLE &&
      !changed_ff && !dropped_ff)
      else $error("summary did not close the transaction");

   a_present_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptwa_pkg::ST_EMIT |-> pres_ff <= count_ff)
      else $error("present total above entry total");

   a_no_result_on_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptwa_pkg::ST_SEARCH |=> !rsp_valid_ff)
      else $error("result during table search");

endmodule
